// ===== hdl/lesf_pkg.sv =====
// Shared types, widths and codes of the lowest-energy split finder.
`default_nettype none
package lesf_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_WINDOW_DEF = 4096;
    localparam int START_W        = 32;
    localparam int LEN_W          = 25;
    localparam int POS_W          = 33;
    localparam int WIN_W          = 13;
    localparam int FLOOR_W        = 43;
    localparam int CFG_DATA_W     = 43;
    localparam int CFG_IDX_W      = 1;
    localparam int SQ_W           = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W          = 64;

    // Divide by five: multiply by the rounded-up reciprocal and shift.
    localparam logic [31:0] DIV5_MUL   = 32'hCCCC_CCCD;
    localparam int          DIV5_SHIFT = 34;

    localparam logic [WIN_W-1:0]   WINDOW_RESET = 13'd1600;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET  = 43'd172;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 1'd1;

    localparam logic MODE_BEGIN  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic [WIN_W-1:0]   window;
        logic [FLOOR_W-1:0] silence_floor;
    } cfg_t;

    typedef struct packed {
        logic [START_W-1:0] base;
        logic [LEN_W-1:0]   offset;
        logic               midpoint;
    } res_t;

endpackage
`default_nettype wire

// ===== hdl/lesf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lesf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lesf_core.sv =====
// Region tracking, squared-sample ring and sliding-window ranking.
`default_nettype none
module lesf_core #(
    parameter int MAX_WINDOW = lesf_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_mode,
    input  wire logic [lesf_pkg::START_W-1:0]           s_region_start,
    input  wire logic [lesf_pkg::LEN_W-1:0]             s_region_length,
    input  wire logic signed [lesf_pkg::SAMPLE_BITS-1:0] s_sample,
    input  wire lesf_pkg::cfg_t                         cfg,
    output logic                                        res_valid,
    input  wire logic                                   res_ready,
    output lesf_pkg::res_t                              res
);
    import lesf_pkg::*;

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int PROD_W = DIV5_SHIFT + LEN_W;

    // input stage
    logic                    a_valid_reg;
    logic                    a_mode_reg;
    logic [START_W-1:0]      a_start_reg;
    logic [LEN_W-1:0]        a_len_reg;
    logic [SAMPLE_BITS-1:0]  a_sample_reg;

    // work stage
    logic                    b_valid_reg;
    logic                    b_mode_reg;
    logic [START_W-1:0]      b_start_reg;
    logic [LEN_W-1:0]        b_len_reg;
    logic [SQ_W-1:0]         b_sq_reg;
    logic [LEN_W-1:0]        b_fifth_reg;

    // region state
    logic [START_W-1:0] base_reg,   base_next;
    logic [LEN_W-1:0]   len_reg,    len_next;
    logic [LEN_W-1:0]   low_reg,    low_next;
    logic [LEN_W-1:0]   high_reg,   high_next;
    logic [LEN_W-1:0]   seen_reg,   seen_next;
    logic [LEN_W-1:0]   k_reg,      k_next;
    logic [PTR_W-1:0]   wp_reg,     wp_next;
    logic [SUM_W-1:0]   sum_reg,    sum_next;
    logic [PTR_W-1:0]   phase_reg,  phase_next;
    logic [FLOOR_W-1:0] best_reg,   best_next;
    logic [LEN_W-1:0]   centre_reg, centre_next;
    logic               found_reg,  found_next;

    logic                   b_adv;
    logic                   b_emit;
    logic                   commit;
    logic [SAMPLE_BITS:0]   mag;
    logic [2*SAMPLE_BITS+1:0] sq_full;
    logic [PROD_W-1:0]      fifth_full;
    logic [WIN_W-2:0]       hop;
    logic                   live;
    logic [LEN_W-1:0]       seen_inc;
    logic                   in_range;
    logic                   k_ge_w;
    logic                   full_win;
    logic [SUM_W-1:0]       sum_new;
    logic [SUM_W-1:0]       rank;
    logic [PTR_W-1:0]       p0;
    logic [PTR_W-1:0]       p1;
    logic [PTR_W-1:0]       phase_adv;
    logic                   better;
    logic [LEN_W-1:0]       centre_new;
    logic                   found_upd;
    logic [LEN_W-1:0]       centre_upd;
    logic                   last;
    logic                   too_short;
    logic [LEN_W-1:0]       mid_default;
    logic [LEN_W-1:0]       high_begin;
    logic [PTR_W-1:0]       wp_inc;
    logic [31:0]            rd_diff;
    logic [PTR_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [SQ_W-1:0]        rd_data;

    assign s_ready = !a_valid_reg || b_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            a_mode_reg   <= s_mode;
            a_start_reg  <= s_region_start;
            a_len_reg    <= s_region_length;
            a_sample_reg <= s_sample;
        end
    end

    assign mag = a_sample_reg[SAMPLE_BITS-1]
               ? (SAMPLE_BITS+1)'((SAMPLE_BITS+1)'(1) << SAMPLE_BITS)
                 - (SAMPLE_BITS+1)'(a_sample_reg)
               : (SAMPLE_BITS+1)'(a_sample_reg);
    assign sq_full    = (2*SAMPLE_BITS+2)'(mag) * (2*SAMPLE_BITS+2)'(mag);
    assign fifth_full = PROD_W'(a_len_reg) * PROD_W'(DIV5_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_adv) begin
            b_valid_reg <= a_valid_reg;
        end
        if (b_adv && a_valid_reg) begin
            b_mode_reg  <= a_mode_reg;
            b_start_reg <= a_start_reg;
            b_len_reg   <= a_len_reg;
            b_sq_reg    <= sq_full[SQ_W-1:0];
            b_fifth_reg <= fifth_full[DIV5_SHIFT +: LEN_W];
        end
    end

    assign hop      = cfg.window[WIN_W-1:1];
    assign live     = seen_reg < len_reg;
    assign seen_inc = seen_reg + LEN_W'(1);
    assign in_range = (seen_reg >= low_reg) && (seen_reg < high_reg);
    assign k_ge_w   = k_reg >= LEN_W'(cfg.window);
    assign full_win = ((LEN_W+1)'(k_reg) + (LEN_W+1)'(1)) >= (LEN_W+1)'(cfg.window);
    assign sum_new  = sum_reg - (k_ge_w ? SUM_W'(rd_data) : SUM_W'(0)) + SUM_W'(b_sq_reg);
    assign rank     = (sum_new == '0) ? SUM_W'(cfg.silence_floor) : sum_new;

    assign p0        = (32'(phase_reg) >= 32'(hop)) ? '0 : phase_reg;
    assign p1        = p0 + PTR_W'(1);
    assign phase_adv = (32'(p1) >= 32'(hop)) ? '0 : p1;
    assign better    = in_range && full_win && (p0 == '0) && (rank < SUM_W'(best_reg));

    assign centre_new  = seen_inc - LEN_W'(cfg.window) + LEN_W'(hop);
    assign found_upd   = found_reg || better;
    assign centre_upd  = better ? centre_new : centre_reg;
    assign last        = seen_inc == len_reg;
    assign too_short   = (LEN_W+1)'(high_reg)
                         <= (LEN_W+1)'(low_reg) + (LEN_W+1)'(cfg.window);
    assign mid_default = low_reg + ((high_reg - low_reg) >> 1);
    assign high_begin  = b_len_reg - b_fifth_reg;
    assign wp_inc      = (wp_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_reg + PTR_W'(1);

    always_comb begin
        b_emit = 1'b0;
        res    = '0;
        if (b_valid_reg) begin
            if (b_mode_reg == MODE_BEGIN) begin
                b_emit       = (b_len_reg == '0);
                res.base     = b_start_reg;
                res.offset   = '0;
                res.midpoint = 1'b1;
            end else begin
                b_emit       = live && last;
                res.base     = base_reg;
                res.midpoint = too_short;
                if (too_short) begin
                    res.offset = len_reg >> 1;
                end else if (found_upd) begin
                    res.offset = centre_upd;
                end else begin
                    res.offset = mid_default;
                end
            end
        end
    end

    assign res_valid = b_emit;
    assign b_adv     = !(b_valid_reg && b_emit && !res_ready);
    assign commit    = b_valid_reg && b_adv;

    always_comb begin
        base_next   = base_reg;
        len_next    = len_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        seen_next   = seen_reg;
        k_next      = k_reg;
        wp_next     = wp_reg;
        sum_next    = sum_reg;
        phase_next  = phase_reg;
        best_next   = best_reg;
        centre_next = centre_reg;
        found_next  = found_reg;
        wr_en       = 1'b0;
        if (commit) begin
            if (b_mode_reg == MODE_BEGIN) begin
                base_next  = b_start_reg;
                len_next   = b_len_reg;
                low_next   = b_fifth_reg;
                high_next  = high_begin;
                seen_next  = '0;
                k_next     = '0;
                wp_next    = '0;
                sum_next   = '0;
                phase_next = '0;
                best_next  = '1;
                found_next = 1'b0;
            end else if (live) begin
                seen_next = seen_inc;
                if (in_range) begin
                    wr_en    = 1'b1;
                    k_next   = k_reg + LEN_W'(1);
                    wp_next  = wp_inc;
                    sum_next = sum_new;
                    if (full_win) begin
                        phase_next = phase_adv;
                    end
                    if (better) begin
                        best_next   = rank[FLOOR_W-1:0];
                        centre_next = centre_new;
                        found_next  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            seen_reg  <= '0;
            found_reg <= 1'b0;
        end else begin
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            found_reg <= found_next;
        end
        base_reg   <= base_next;
        low_reg    <= low_next;
        high_reg   <= high_next;
        k_reg      <= k_next;
        wp_reg     <= wp_next;
        sum_reg    <= sum_next;
        phase_reg  <= phase_next;
        best_reg   <= best_next;
        centre_reg <= centre_next;
    end

    // fetch the entry leaving the window for the item that enters next
    always_comb begin
        rd_diff = 32'(wp_next) + 32'(MAX_WINDOW) - 32'(cfg.window);
        if (rd_diff >= 32'(MAX_WINDOW)) begin
            rd_diff = rd_diff - 32'(MAX_WINDOW);
        end
        rd_addr = rd_diff[PTR_W-1:0];
    end

    lesf_ram #(
        .WIDTH (SQ_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (b_sq_reg),
        .rd_en   (b_adv),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
`default_nettype wire

// ===== hdl/lesf_out.sv =====
// Result holding stage and output register with the final position add.
`default_nettype none
module lesf_out (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       res_valid,
    output logic                            res_ready,
    input  wire lesf_pkg::res_t             res,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [lesf_pkg::POS_W-1:0]      m_split_position,
    output logic                            m_used_midpoint
);
    import lesf_pkg::*;

    logic             r_valid_reg;
    res_t             r_res_reg;
    logic             m_valid_reg;
    logic [POS_W-1:0] m_pos_reg;
    logic             m_mid_reg;
    logic             m_load;

    assign m_load    = r_valid_reg && (!m_valid_reg || m_ready);
    assign res_ready = !r_valid_reg || m_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_valid_reg <= 1'b1;
            end else if (m_load) begin
                r_valid_reg <= 1'b0;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (res_valid && res_ready) begin
            r_res_reg <= res;
        end
        if (m_load) begin
            m_pos_reg <= POS_W'(r_res_reg.base) + POS_W'(r_res_reg.offset);
            m_mid_reg <= r_res_reg.midpoint;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_split_position = m_pos_reg;
    assign m_used_midpoint  = m_mid_reg;

endmodule
`default_nettype wire

// ===== hdl/lowest_energy_split_finder.sv =====
// Top level of the lowest-energy split finder: configuration registers and wiring.
//
// Use: send a begin item (mode 0) with the region's absolute start and length L,
// then L sample items (mode 1). The block ranks windows of window_samples samples,
// stepped by half a window, over the middle part of the region by sum of squares
// and returns one item per region: the absolute centre of the quietest window, or
// the region midpoint with used_midpoint set when the middle part is too short.
// A begin item with L of zero returns its start at once with used_midpoint set.
// Both channels are valid/ready; configuration is a plain write port.
// Throughput is one item per cycle while no result is stalled: each sample
// takes one square, one read and one write of the squared-sample ring RAM and
// one compare. The ring read for an item is issued early, while the item sits
// in the input register. The final sample (or an empty begin item) passes from
// the input register through the work and holding stages to the output register.
// Reset closes any region: samples are dropped until a begin item arrives;
// window_samples returns to 1600 and silence_floor to 172. The ring needs no
// clearing. When the receiver stalls, the result holds in the output register
// and one further result waits in a holding stage; s_ready drops only when a
// third result would need room.
`default_nettype none
module lowest_energy_split_finder #(
    parameter int MAX_WINDOW = lesf_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic                                    s_mode,
    input  wire logic [lesf_pkg::START_W-1:0]            s_region_start,
    input  wire logic [lesf_pkg::LEN_W-1:0]              s_region_length,
    input  wire logic signed [lesf_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [lesf_pkg::POS_W-1:0]                   m_split_position,
    output logic                                         m_used_midpoint,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [lesf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [lesf_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import lesf_pkg::*;

    localparam logic [WIN_W-1:0] WIN_RST = (32'(WINDOW_RESET) > MAX_WINDOW)
                                         ? WIN_W'(MAX_WINDOW) : WINDOW_RESET;

    logic [WIN_W-1:0]   window_reg;
    logic [FLOOR_W-1:0] floor_reg;
    logic [WIN_W-1:0]   win_raw;
    logic [WIN_W-1:0]   win_lo;
    logic [WIN_W-1:0]   win_clamped;
    cfg_t               cfg;
    logic               res_valid;
    logic               res_ready;
    res_t               res;

    // clamp the window to its legal range on write
    assign win_raw     = cfg_data[WIN_W-1:0];
    assign win_lo      = (win_raw < WIN_W'(2)) ? WIN_W'(2) : win_raw;
    assign win_clamped = (32'(win_lo) > 32'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_lo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WIN_RST;
            floor_reg  <= FLOOR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WINDOW: begin
                    window_reg <= win_clamped;
                end
                CFG_FLOOR: begin
                    floor_reg <= cfg_data[FLOOR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.window        = window_reg;
    assign cfg.silence_floor = floor_reg;

    lesf_core #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_region_start  (s_region_start),
        .s_region_length (s_region_length),
        .s_sample        (s_sample),
        .cfg             (cfg),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    lesf_out u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_split_position (m_split_position),
        .m_used_midpoint  (m_used_midpoint)
    );

endmodule
`default_nettype wire

// ===== hdl/lesf_checker.sv =====
// Port-level assertions for the split finder, bound to the top level.
`default_nettype none
module lesf_checker (
    input wire logic                                    aclk,
    input wire logic                                    aresetn,
    input wire logic                                    s_valid,
    input wire logic                                    s_ready,
    input wire logic                                    s_mode,
    input wire logic [lesf_pkg::START_W-1:0]            s_region_start,
    input wire logic [lesf_pkg::LEN_W-1:0]              s_region_length,
    input wire logic                                    m_valid,
    input wire logic                                    m_ready,
    input wire logic [lesf_pkg::POS_W-1:0]              m_split_position,
    input wire logic                                    m_used_midpoint
);
    import lesf_pkg::*;

    // an item that cannot be taken is only ever due to a stalled result
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a stalled result");

    // an empty region returns its start with used_midpoint set when never stalled
    a_empty_region: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_mode == MODE_BEGIN) && (s_region_length == '0))
        ##1 m_ready ##1 m_ready ##1 m_ready
        |=> (m_valid && m_used_midpoint
             && (m_split_position == {1'b0, $past(s_region_start, 4)})))
        else $error("empty region result wrong or late");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
        (m_valid && $stable(m_split_position) && $stable(m_used_midpoint)))
        else $error("stalled result changed");

endmodule

bind lowest_energy_split_finder lesf_checker u_lesf_checker (.*);
`default_nettype wire

// ===== tb/tb_lowest_energy_split_finder.sv =====
// Testbench for the lowest-energy split finder: directed and random regions.
module tb_lowest_energy_split_finder;
    timeunit 1ns;
    timeprecision 1ps;

    import lesf_pkg::*;

    localparam int              RING_DEPTH     = MAX_WINDOW_DEF;
    localparam longint unsigned NO_ENERGY      = (64'd1 << FLOOR_W) - 64'd1;
    localparam logic [FLOOR_W-1:0] FLOOR_ALL_ONES = '1;
    localparam int              SETTLE_CYCLES  = 8;
    localparam int              RANDOM_ITEMS   = 500;
    localparam longint          TIMEOUT_NS     = 20_000_000;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             midpoint;
    } split_t;

    class split_scoreboard;
        logic [WIN_W-1:0]   window_reg;
        logic [FLOOR_W-1:0] floor_reg;
        longint unsigned    square_ring [RING_DEPTH];
        longint unsigned    energy;
        longint unsigned    seen;
        longint unsigned    base;
        longint unsigned    length;
        longint unsigned    low_edge;
        longint unsigned    high_edge;
        longint unsigned    hop_phase;
        longint unsigned    best_energy;
        longint unsigned    best_centre;
        split_t             expected_splits [$];
        int unsigned        mismatches;

        function new();
            window_reg = WINDOW_RESET;
            floor_reg = FLOOR_RESET;
            foreach (square_ring[i]) square_ring[i] = 0;
            energy = 0;
            seen = 0;
            base = 0;
            length = 0;
            low_edge = 0;
            high_edge = 0;
            hop_phase = 0;
            best_energy = NO_ENERGY;
            best_centre = 0;
            mismatches = 0;
        endfunction

        function void queue_split(split_t item);
            expected_splits = {expected_splits, item};
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == CFG_WINDOW) window_reg = value[WIN_W-1:0];
            else if (index == CFG_FLOOR) floor_reg = value[FLOOR_W-1:0];
        endfunction

        function longint unsigned window_len();
            if (window_reg < 2) return 2;
            if (window_reg > RING_DEPTH) return RING_DEPTH;
            return 64'(window_reg);
        endfunction

        function void note_item(logic mode, logic [START_W-1:0] start,
                                logic [LEN_W-1:0] len_in,
                                logic signed [SAMPLE_BITS-1:0] smp);
            longint unsigned w;
            longint unsigned hop;
            longint unsigned idx;
            longint unsigned k;
            longint unsigned rank;
            longint signed   level;
            split_t          res;
            w = window_len();
            hop = w / 2;
            if (mode == MODE_BEGIN) begin
                base = start;
                length = len_in;
                low_edge = length / 5;
                high_edge = length - length / 5;
                seen = 0;
                energy = 0;
                hop_phase = 0;
                best_energy = NO_ENERGY;
                best_centre = low_edge + (high_edge - low_edge) / 2;
                if (length == 0) begin
                    res.position = POS_W'(base);
                    res.midpoint = 1'b1;
                    queue_split(res);
                end
                return;
            end
            if (seen >= length) return;
            idx = seen;
            seen++;
            if (idx >= low_edge && idx < high_edge) begin
                k = idx - low_edge;
                level = smp;
                if (level < 0) level = -level;
                if (k >= w) energy -= square_ring[(k - w) % RING_DEPTH];
                square_ring[k % RING_DEPTH] = level * level;
                energy += level * level;
                if (k + 1 >= w) begin
                    if (hop_phase >= hop) hop_phase = 0;
                    if (hop_phase == 0) begin
                        rank = (energy == 0) ? 64'(floor_reg) : energy;
                        if (rank < best_energy) begin
                            best_energy = rank;
                            best_centre = idx + 1 - w + w / 2;
                        end
                    end
                    hop_phase++;
                    if (hop_phase >= hop) hop_phase = 0;
                end
            end
            if (seen == length) begin
                if (high_edge <= low_edge + w) begin
                    res.position = POS_W'(base + length / 2);
                    res.midpoint = 1'b1;
                end else begin
                    res.position = POS_W'(base + best_centre);
                    res.midpoint = 1'b0;
                end
                queue_split(res);
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 50) $display("%0t ns: %s", $time, what);
        endtask

        task check_split(logic [POS_W-1:0] position, logic midpoint);
            split_t want;
            if (expected_splits.size() == 0) begin
                report_mismatch($sformatf("split at %0h with none pending", position));
                return;
            end
            want = expected_splits.pop_front();
            if (position !== want.position)
                report_mismatch($sformatf("split_position %0h, want %0h",
                                          position, want.position));
            if (midpoint !== want.midpoint)
                report_mismatch($sformatf("used_midpoint %b, want %b",
                                          midpoint, want.midpoint));
        endtask
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_mode = MODE_SAMPLE;
    logic [START_W-1:0]            s_region_start = '0;
    logic [LEN_W-1:0]              s_region_length = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [POS_W-1:0]              m_split_position;
    logic                          m_used_midpoint;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = CFG_WINDOW;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    split_scoreboard book = new();
    bit              steady = 1'b0;
    int unsigned     hold_cycles = 0;
    int unsigned     region_items = 0;

    lowest_energy_split_finder dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady) return 0;
        roll = $urandom_range(0, 19);
        if (roll < 10) return 0;
        if (roll < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int unsigned quiet);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < quiet) return '0;
        if (roll < 8) return SAMPLE_BITS'($signed($urandom_range(0, 8)) - 4);
        return SAMPLE_BITS'($urandom);
    endfunction

    function automatic logic [WIN_W-1:0] pick_window();
        case ($urandom_range(0, 7))
            0: return WIN_W'(0);
            1: return WIN_W'(1);
            2: return WIN_W'(2);
            3: return WIN_W'(3);
            default: return WIN_W'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [FLOOR_W-1:0] pick_floor();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return FLOOR_ALL_ONES;
            2: return FLOOR_RESET;
            3: return FLOOR_W'({$urandom, $urandom});
            default: return FLOOR_W'($urandom_range(0, 2000));
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            book.check_split(m_split_position, m_used_midpoint);
        if (hold_cycles != 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            hold_cycles = pick_gap();
        end
    end

    task automatic send_item(input logic mode, input logic [START_W-1:0] start,
                             input logic [LEN_W-1:0] len,
                             input logic signed [SAMPLE_BITS-1:0] smp);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_region_start <= start;
        s_region_length <= len;
        s_sample <= smp;
        do @(posedge aclk); while (s_ready !== 1'b1);
        book.note_item(mode, start, len, smp);
    endtask

    task automatic send_begin(input logic [START_W-1:0] start, input logic [LEN_W-1:0] len);
        send_item(MODE_BEGIN, start, len, SAMPLE_BITS'($urandom));
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        send_item(MODE_SAMPLE, $urandom, LEN_W'($urandom), smp);
    endtask

    // hold the sender until every split is back and the pipeline has emptied
    task automatic drain();
        s_valid <= 1'b0;
        while (book.expected_splits.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [WIN_W-1:0] win, input logic [FLOOR_W-1:0] flr);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WINDOW;
        cfg_data <= CFG_DATA_W'(win);
        @(posedge aclk);
        book.write_reg(CFG_WINDOW, CFG_DATA_W'(win));
        cfg_index <= CFG_FLOOR;
        cfg_data <= CFG_DATA_W'(flr);
        @(posedge aclk);
        book.write_reg(CFG_FLOOR, CFG_DATA_W'(flr));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_region(input logic [START_W-1:0] start, input int unsigned len,
                               input int unsigned quiet, input int unsigned count,
                               input int unsigned cut);
        send_begin(start, LEN_W'(len));
        for (int unsigned n = 0; n < count; n++) begin
            if (cut != 0 && n == cut) set_config(pick_window(), book.floor_reg);
            send_sample(pick_sample(quiet));
        end
        region_items += count + 1;
    endtask

    initial begin
        int unsigned kind;
        int unsigned len;
        int unsigned quiet;
        int unsigned cut;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // drop samples before any region and past a region's end; empty and huge regions
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_begin(32'hFFFF_FFFF, 25'd2);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        send_sample(16'sh1234);
        send_begin(32'h1234_5678, 25'd0);
        send_begin(32'h0000_0000, 25'h0FF_FFFF);
        send_begin(32'h5555_AAAA, 25'h100_0000);
        send_begin(32'h0000_0000, 25'd1);
        send_sample(16'sh7FFF);

        set_config(WIN_W'(0), '0);
        send_begin(32'd100, 25'd5);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        send_sample(16'sh0003);
        send_sample(16'sh7FFF);

        set_config(WIN_W'(1), FLOOR_ALL_ONES);
        send_begin(32'd200, 25'd5);
        repeat (5) send_sample(16'sh0000);

        while (region_items < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 3) == 0);
            set_config(pick_window(), pick_floor());
            repeat ($urandom_range(1, 4)) begin
                kind = $urandom_range(0, 9);
                len = $urandom_range(1, 40);
                quiet = $urandom_range(0, 10);
                if (kind == 0) begin
                    repeat ($urandom_range(1, 3)) send_sample(pick_sample(quiet));
                end else if (kind == 1) begin
                    send_region($urandom, len, quiet, $urandom_range(0, len - 1), 0);
                end else begin
                    cut = (kind == 2 && len > 1) ? $urandom_range(1, len - 1) : 0;
                    send_region($urandom, len, quiet, len, cut);
                end
            end
        end

        // widest window, clamped to the ring depth
        steady = 1'b0;
        set_config(WIN_W'(8191), pick_floor());
        send_region($urandom, 40, $urandom_range(0, 3), 40, 0);
        set_config(WIN_W'(4096), pick_floor());
        send_region($urandom, 40, 5, 40, 0);

        drain();
        if (book.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lesf_pkg.sv
hdl/lesf_ram.sv
hdl/lesf_core.sv
hdl/lesf_out.sv
hdl/lowest_energy_split_finder.sv
hdl/lesf_checker.sv
tb/tb_lowest_energy_split_finder.sv
